>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MRED_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MRED_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mred_pkg.sv
`default_nettype none

package mred_pkg;

    // Lane geometry: each expander port carries eight encoders.
    localparam int LANES_MAX            = 16;
    localparam int PORT_LANES           = 8;
    localparam int NUM_ENCODERS_DEFAULT = 16;

    // Field widths.
    localparam int PORT_W    = 8;
    localparam int TIME_W    = 32;
    localparam int LOCKOUT_W = 16;
    localparam int MASK_W    = 16;

    // Bit that selects one lane out of a shifted port snapshot.
    localparam logic [PORT_W-1:0] LANE_BIT = 8'h01;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (word address bits of paddr).
    localparam logic REG_LOCKOUT = 1'b0;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd5;

    // One poll of all encoders.
    typedef struct packed {
        logic [PORT_W-1:0] exp1_port_a;
        logic [PORT_W-1:0] exp1_port_b;
        logic [PORT_W-1:0] exp2_port_a;
        logic [PORT_W-1:0] exp2_port_b;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    // Steps found in one poll.
    typedef struct packed {
        logic [MASK_W-1:0] up_mask;
        logic [MASK_W-1:0] down_mask;
    } steps_t;

    // What one lane reports to the merging stage.
    typedef struct packed {
        logic up;
        logic down;
    } lane_step_t;

endpackage

`default_nettype wire

>>> rtl/mred_cfg.sv
`default_nettype none

module mred_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mred_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mred_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mred_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output logic      [mred_pkg::LOCKOUT_W-1:0]  lockout_ms
);
    import mred_pkg::*;

    logic                 reg_index;
    logic                 wr_en;
    logic [LOCKOUT_W-1:0] lockout_reg;
    logic [LOCKOUT_W-1:0] lockout_next;

    // Registers sit on 32-bit words; the byte offset is ignored.
    assign reg_index = paddr[2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    // Write decode for the lockout register.
    always_comb
    begin
        lockout_next = lockout_reg;
        if (wr_en && (reg_index == REG_LOCKOUT))
        begin
            lockout_next = pwdata[LOCKOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= LOCKOUT_RESET;
        end
        else
        begin
            lockout_reg <= lockout_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_index)
            REG_LOCKOUT: prdata = {{(APB_DATA_W-LOCKOUT_W){1'b0}}, lockout_reg};
            default:     prdata = '0;
        endcase
    end

    assign lockout_ms = lockout_reg;

endmodule

`default_nettype wire

>>> rtl/mred_lane.sv
`default_nettype none

`include "assert_macros.svh"

module mred_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic                          a_line,
    input  wire logic                          b_line,
    input  wire logic [mred_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [mred_pkg::LOCKOUT_W-1:0] lockout_ms,
    output mred_pkg::lane_step_t               step
);
    import mred_pkg::*;

    logic              prev_a_reg;
    logic              prev_a_next;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] last_time_next;
    logic [TIME_W-1:0] elapsed_ms;
    logic              a_fell;
    logic              past_lockout;
    logic              stamp_late;
    logic              step_go;

    // Falling edge on A, gated by the wrapping time since the last step.
    assign elapsed_ms   = now_ms - last_time_reg;
    assign a_fell       = prev_a_reg & ~a_line;
    assign past_lockout = elapsed_ms > {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_ms};
    assign stamp_late   = last_time_reg > now_ms;
    assign step_go      = a_fell & past_lockout;

    assign step.up   = step_go & b_line;
    assign step.down = step_go & ~b_line;

    // State update, taken only when the poll transaction is accepted.
    always_comb
    begin
        prev_a_next    = prev_a_reg;
        last_time_next = last_time_reg;
        if (fire)
        begin
            prev_a_next = a_line;
            if (step_go)
            begin
                last_time_next = now_ms;
            end
            else if (stamp_late)
            begin
                last_time_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg    <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            prev_a_reg    <= prev_a_next;
            last_time_reg <= last_time_next;
        end
    end

    // A reported step stamps the event time with the poll's time.
    `MRED_ASSERT_NEXT(a_step_stamps_time, clk, rst_n, fire && step_go, last_time_reg == $past(now_ms), "lane step did not record its time")
    // Without a step, the stored time never ends up later than the poll's time.
    `MRED_ASSERT_NEXT(a_no_future_stamp, clk, rst_n, fire && !step_go, last_time_reg <= $past(now_ms), "lane kept an event time later than now")

endmodule

`default_nettype wire

>>> rtl/mred_merge.sv
`default_nettype none

`include "assert_macros.svh"

module mred_merge (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        poll_valid,
    output logic                                             poll_ready,
    input  wire mred_pkg::lane_step_t [mred_pkg::LANES_MAX-1:0] lane_steps,
    output logic                                             steps_valid,
    input  wire logic                                        steps_ready,
    output mred_pkg::steps_t                                 steps,
    output logic                                             fire
);
    import mred_pkg::*;

    logic   out_valid_reg;
    logic   out_valid_next;
    steps_t out_reg;
    steps_t merged;

    // Gather the lane results into the two masks.
    always_comb
    begin
        merged = '0;
        for (int k = 0; k < LANES_MAX; k++)
        begin
            merged.up_mask[k]   = lane_steps[k].up;
            merged.down_mask[k] = lane_steps[k].down;
        end
    end

    // The output register takes a new poll whenever it is empty or being drained.
    assign poll_ready = ~out_valid_reg | steps_ready;
    assign fire       = poll_valid & poll_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (steps_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= merged;
        end
    end

    assign steps_valid = out_valid_reg;
    assign steps       = out_reg;

    // Every accepted poll leaves a result waiting in the next cycle.
    `MRED_ASSERT_NEXT(a_poll_gives_result, clk, rst_n, fire, out_valid_reg, "accepted poll produced no result")
    // An encoder never steps both ways in one poll.
    `MRED_ASSERT_SAME(a_masks_disjoint, clk, rst_n, out_valid_reg, (out_reg.up_mask & out_reg.down_mask) == '0, "encoder stepped up and down at once")

endmodule

`default_nettype wire

>>> rtl/multi_rotary_encoder_decoder_top.sv
// Channel    Direction  Signals                          Carries
// poll       in         poll_valid, poll_ready, poll     four port snapshots and the time
// steps      out        steps_valid, steps_ready, steps  up and down step masks
// config     in/out     psel, penable, pwrite, paddr,    lockout register at address 0
//                       pwdata, prdata, pready
//
// One poll is accepted per cycle while poll_ready is high; its masks appear in the output register in the next cycle.
// All encoder lanes compare their 32-bit elapsed time in parallel, combinationally.
// The output register refills in the cycle it is drained, so draining costs no throughput.
// poll_ready drops only while a result is held and steps_ready is low.
// Reset clears every lane's previous A line and event time and sets the lockout to 5 ms.

`default_nettype none

module multi_rotary_encoder_decoder_top #(
    parameter int NUM_ENCODERS = mred_pkg::NUM_ENCODERS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            poll_valid,
    output logic                                 poll_ready,
    input  wire mred_pkg::poll_t                 poll,
    output logic                                 steps_valid,
    input  wire logic                            steps_ready,
    output mred_pkg::steps_t                     steps,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mred_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mred_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mred_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import mred_pkg::*;

    localparam int NumLanes = (NUM_ENCODERS > LANES_MAX) ? LANES_MAX : NUM_ENCODERS;

    logic                            fire;
    logic [LOCKOUT_W-1:0]            lockout_ms;
    lane_step_t [LANES_MAX-1:0]      lane_steps;

    // Configuration register.
    mred_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .lockout_ms (lockout_ms)
    );

    // One lane per encoder; lanes past the encoder count report nothing.
    for (genvar k = 0; k < LANES_MAX; k++)
    begin : g_lane
        localparam int Pos = k % PORT_LANES;
        localparam int Exp = k / PORT_LANES;

        if (k < NumLanes)
        begin : g_used
            logic [PORT_W-1:0] port_a;
            logic [PORT_W-1:0] port_b;
            logic [PORT_W-1:0] a_bits;
            logic [PORT_W-1:0] b_bits;

            assign port_a = (Exp == 0) ? poll.exp1_port_a : poll.exp2_port_a;
            assign port_b = (Exp == 0) ? poll.exp1_port_b : poll.exp2_port_b;
            assign a_bits = (port_a >> Pos) & LANE_BIT;
            assign b_bits = (port_b >> Pos) & LANE_BIT;

            mred_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .fire       (fire),
                .a_line     (a_bits[0]),
                .b_line     (b_bits[0]),
                .now_ms     (poll.now_ms),
                .lockout_ms (lockout_ms),
                .step       (lane_steps[k])
            );
        end
        else
        begin : g_unused
            assign lane_steps[k] = '0;
        end
    end

    // Mask assembly and output register.
    mred_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .poll_valid  (poll_valid),
        .poll_ready  (poll_ready),
        .lane_steps  (lane_steps),
        .steps_valid (steps_valid),
        .steps_ready (steps_ready),
        .steps       (steps),
        .fire        (fire)
    );

endmodule

`default_nettype wire
